### rtl/l2c_pkg.sv
// ----------------------------------------------------------------------------
// l2c_pkg
// Shared types and constants of the latitude/longitude to Cartesian converter.
// ----------------------------------------------------------------------------
`default_nettype none

package l2c_pkg;

  // Angle units: 1/128 degree
  localparam logic [15:0] FULL_TURN    = 16'd46080;
  localparam logic [15:0] QUARTER_TURN = 16'd11520;
  localparam logic [15:0] HALF_TURN    = 16'd23040;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd34560;

  // pi/23040 in Q30 scaled by 2^8
  localparam logic [25:0] RAD_SCALE = 26'd37480660;

  // CORDIC datapath widths and start value
  localparam int XY_W = 34;
  localparam int Z_W  = 33;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam int ATAN_ENTRIES = 24;

  // Q16 one and output limit
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [15:0] OUT_MAX = 16'hFFFF;

  // Sine and cosine magnitudes with signs for both angles
  typedef struct packed {
    logic [16:0] lat_sin;
    logic        lat_sin_neg;
    logic [16:0] lat_cos;
    logic        lat_cos_neg;
    logic [16:0] lon_sin;
    logic        lon_sin_neg;
    logic [16:0] lon_cos;
    logic        lon_cos_neg;
  } trig_t;

  // atan(2^-i) in Q30, rounded
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/latlong_to_cartesian.sv
// ----------------------------------------------------------------------------
// latlong_to_cartesian
// Converts a latitude/longitude pair to a point on a sphere of the
// programmed radius.
// ----------------------------------------------------------------------------
// Accepts one angle pair per clock while in_stall is low and returns one point
// per pair, in order. The pipeline performs range reduction, radian scaling,
// one CORDIC rotation stage per iteration and rounding, then the product,
// radius multiply and round/saturate stages. The
// pipeline is bubble-collapsing, so items keep entering while a finished point
// waits on out_stall, until every stage is full. Program radius only while no
// transaction is in flight.
`default_nettype none

module latlong_to_cartesian #(
  parameter int TRIG_STAGES = 16,
  parameter int RADIUS_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               radius_we,
  input  wire logic [15:0]        radius,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        latitude,
  input  wire logic [15:0]        longitude,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      x_coord,
  output logic signed [16:0]      y_coord,
  output logic signed [16:0]      z_coord
);

  localparam int RW = (RADIUS_BITS < 16) ? RADIUS_BITS : 16;

  // Hold the radius register
  logic [RW-1:0] radius_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_q <= '0;
    end else if (radius_we) begin
      radius_q <= radius[RW-1:0];
    end
  end

  logic           in_ready;
  logic           trig_valid;
  logic           trig_ready;
  l2c_pkg::trig_t trig;

  assign in_stall = !in_ready;

  l2c_sincos #(
    .TRIG_STAGES(TRIG_STAGES)
  ) u_sincos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .lat_angle (latitude),
    .lon_angle (longitude),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_trig  (trig)
  );

  l2c_scale #(
    .RW(RW)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius_q),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_trig   (trig),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .z_coord   (z_coord)
  );

endmodule

`default_nettype wire

### rtl/l2c_sincos.sv
// ----------------------------------------------------------------------------
// l2c_sincos
// Pipelined sine/cosine of the latitude and longitude angles: range
// reduction, radian scaling, one CORDIC rotation per stage, Q16 rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module l2c_sincos #(
  parameter int TRIG_STAGES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [15:0]   lat_angle,
  input  wire logic [15:0]   lon_angle,
  output logic               out_valid,
  input  wire logic          out_ready,
  output l2c_pkg::trig_t     out_trig
);

  localparam int NS = (TRIG_STAGES < l2c_pkg::ATAN_ENTRIES) ? TRIG_STAGES
                                                            : l2c_pkg::ATAN_ENTRIES;
  localparam int N  = NS + 3;
  localparam int XW = l2c_pkg::XY_W;
  localparam int ZW = l2c_pkg::Z_W;

  logic [N-1:0] vld;
  logic [N:0]   rdy;

  // Ready ripples back through empty or moving stages
  assign rdy[N] = out_ready;
  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  endgenerate
  assign in_ready  = rdy[0];
  assign out_valid = vld[N-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < N; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  logic [15:0] ang [2];
  assign ang[0] = lat_angle;
  assign ang[1] = lon_angle;

  // Stage 0: wrap and split into quadrant and remainder
  logic [13:0] rem0  [2];
  logic [1:0]  quad0 [2];
  logic [15:0] wrap  [2];
  logic [15:0] base  [2];
  logic [1:0]  qsel  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      wrap[l] = (ang[l] >= l2c_pkg::FULL_TURN) ? ang[l] - l2c_pkg::FULL_TURN : ang[l];
      if (wrap[l] >= l2c_pkg::THREE_QUARTER_TURN) begin
        qsel[l] = 2'd3;
        base[l] = l2c_pkg::THREE_QUARTER_TURN;
      end else if (wrap[l] >= l2c_pkg::HALF_TURN) begin
        qsel[l] = 2'd2;
        base[l] = l2c_pkg::HALF_TURN;
      end else if (wrap[l] >= l2c_pkg::QUARTER_TURN) begin
        qsel[l] = 2'd1;
        base[l] = l2c_pkg::QUARTER_TURN;
      end else begin
        qsel[l] = 2'd0;
        base[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < 2; l++) begin
        rem0[l]  <= 14'(wrap[l] - base[l]);
        quad0[l] <= qsel[l];
      end
    end
  end

  // Stage 1: remainder to radians in Q30, load the CORDIC start vector
  logic signed [XW-1:0] cx [NS+1][2];
  logic signed [XW-1:0] cy [NS+1][2];
  logic signed [ZW-1:0] cz [NS+1][2];
  logic [1:0]           qd [NS+1][2];
  logic [39:0]          zprod [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      zprod[l] = 40'(rem0[l]) * 40'(l2c_pkg::RAD_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < 2; l++) begin
        cx[0][l] <= l2c_pkg::CORDIC_GAIN_Q30;
        cy[0][l] <= '0;
        cz[0][l] <= $signed({1'b0, zprod[l][39:8]});
        qd[0][l] <= quad0[l];
      end
    end
  end

  // CORDIC rotation stages
  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_cordic
      localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, l2c_pkg::atan_q30(i)});
      always_ff @(posedge clk) begin
        if (rdy[i+2]) begin
          for (int l = 0; l < 2; l++) begin
            if (!cz[i][l][ZW-1]) begin
              cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
              cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
              cz[i+1][l] <= cz[i][l] - ATAN;
            end else begin
              cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
              cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
              cz[i+1][l] <= cz[i][l] + ATAN;
            end
            qd[i+1][l] <= qd[i][l];
          end
        end
      end
    end
  endgenerate

  // Final stage: round to Q16, clamp, fold in quadrant
  function automatic logic [16:0] to_q16(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    logic signed [XW:0] sh;
    logic [16:0]        r;
    t  = (XW+1)'(v) + (XW+1)'(8192);
    sh = t >>> 14;
    if (sh < 0) begin
      r = '0;
    end else if (sh > (XW+1)'(l2c_pkg::ONE_Q16)) begin
      r = l2c_pkg::ONE_Q16;
    end else begin
      r = sh[16:0];
    end
    return r;
  endfunction

  logic [16:0] rs [2];
  logic [16:0] rc [2];
  logic [16:0] smag [2];
  logic [16:0] cmag [2];
  logic        sneg [2];
  logic        cneg [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rs[l]   = to_q16(cy[NS][l]);
      rc[l]   = to_q16(cx[NS][l]);
      smag[l] = qd[NS][l][0] ? rc[l] : rs[l];
      cmag[l] = qd[NS][l][0] ? rs[l] : rc[l];
      sneg[l] = qd[NS][l][1];
      cneg[l] = qd[NS][l][1] ^ qd[NS][l][0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N-1]) begin
      out_trig.lat_sin     <= smag[0];
      out_trig.lat_sin_neg <= sneg[0];
      out_trig.lat_cos     <= cmag[0];
      out_trig.lat_cos_neg <= cneg[0];
      out_trig.lon_sin     <= smag[1];
      out_trig.lon_sin_neg <= sneg[1];
      out_trig.lon_cos     <= cmag[1];
      out_trig.lon_cos_neg <= cneg[1];
    end
  end

  // Hold a stalled final stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("trig output dropped while stalled");
  a_mag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_trig.lat_sin <= l2c_pkg::ONE_Q16 &&
                  out_trig.lon_cos <= l2c_pkg::ONE_Q16)
    else $error("trig magnitude above one");
  a_entry: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted angles not captured");

endmodule

`default_nettype wire

### rtl/l2c_scale.sv
// ----------------------------------------------------------------------------
// l2c_scale
// Forms the three factor products, scales them by the radius, rounds,
// saturates and applies the signs. The last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module l2c_scale #(
  parameter int RW = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [RW-1:0]       radius,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire l2c_pkg::trig_t      in_trig,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [16:0]       x_coord,
  output logic signed [16:0]       y_coord,
  output logic signed [16:0]       z_coord
);

  logic [2:0] vld;
  logic [3:0] rdy;

  assign rdy[3] = !out_stall;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[2];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
      if (rdy[2]) begin
        vld[2] <= vld[1];
      end
    end
  end

  // Stage 0: factor products in Q32 and result signs
  logic [16:0] fa [3];
  logic [16:0] fb [3];
  logic        ng [3];
  logic [32:0] pm [3];
  logic        neg0 [3];

  always_comb begin
    fa[0] = in_trig.lat_cos;
    fb[0] = in_trig.lon_sin;
    ng[0] = in_trig.lat_cos_neg ^ in_trig.lon_sin_neg;
    fa[1] = in_trig.lat_cos;
    fb[1] = in_trig.lon_cos;
    ng[1] = !in_trig.lat_cos_neg ^ in_trig.lon_cos_neg;
    fa[2] = in_trig.lat_sin;
    fb[2] = l2c_pkg::ONE_Q16;
    ng[2] = in_trig.lat_sin_neg;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < 3; l++) begin
        pm[l]   <= 33'(34'(fa[l]) * 34'(fb[l]));
        neg0[l] <= ng[l];
      end
    end
  end

  // Stage 1: multiply by the radius
  logic [31+RW:0] rp   [3];
  logic           full [3];
  logic           neg1 [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < 3; l++) begin
        rp[l]   <= (32+RW)'(pm[l][31:0]) * (32+RW)'(radius);
        full[l] <= pm[l][32];
        neg1[l] <= neg0[l];
      end
    end
  end

  // Stage 2: round half up, saturate, apply sign
  logic [32+RW:0] rnd [3];
  logic [32:0]    mag [3];
  logic [15:0]    sat [3];
  logic [16:0]    res [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l] = (33+RW)'(rp[l]) + (33+RW)'(33'h080000000);
      mag[l] = full[l] ? 33'(radius) : 33'(rnd[l][32+RW:32]);
      sat[l] = (mag[l] > 33'(l2c_pkg::OUT_MAX)) ? l2c_pkg::OUT_MAX : mag[l][15:0];
      res[l] = (neg1[l] && sat[l] != '0) ? 17'(-17'(sat[l])) : 17'(sat[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      x_coord <= res[0];
      y_coord <= res[1];
      z_coord <= res[2];
    end
  end

  // Results never carry the unused most negative code
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> x_coord != 17'h10000 && y_coord != 17'h10000 &&
                  z_coord != 17'h10000)
    else $error("coordinate out of range");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    vld[1] && rdy[2] && radius == '0 |=> z_coord == '0)
    else $error("nonzero result with zero radius");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[1] && !rdy[2] |=> vld[1])
    else $error("scaled product dropped while stalled");

endmodule

`default_nettype wire

### sim/latlong_to_cartesian_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latlong_to_cartesian_tb
// Drives angle pairs through the converter under random idling on both
// channels, predicts each point with a CORDIC model of its own and compares
// every returned point in order. The radius is reprogrammed between phases.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [16:0] x;
  logic signed [16:0] y;
  logic signed [16:0] z;
} point_t;

class point_scoreboard;
  point_t pending[$];
  point_t last;
  int     errors;

  // Hold an expected point for an accepted angle pair
  function void note_angles(point_t p);
    pending.push_back(p);
  endfunction

  // Compare a returned point with the oldest expectation
  function int check_point(logic signed [16:0] x, logic signed [16:0] y,
                           logic signed [16:0] z);
    point_t e;
    int     bad;
    bad = 0;
    if (pending.size() == 0) return -1;
    e = pending.pop_front();
    last = e;
    if (x !== e.x) bad |= 1;
    if (y !== e.y) bad |= 2;
    if (z !== e.z) bad |= 4;
    return bad;
  endfunction
endclass

module latlong_to_cartesian_tb;

  localparam int STAGES      = 16;
  localparam int RBITS       = 16;
  localparam int LATENCY     = STAGES + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               radius_we = 1'b0;
  logic [15:0]        radius = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        latitude = '0;
  logic [15:0]        longitude = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] x_coord;
  logic signed [16:0] y_coord;
  logic signed [16:0] z_coord;

  point_scoreboard board;
  longint unsigned radius_now;
  int                 fail_count = 0;
  int                 cycles = 0;
  bit                 stall_on = 1'b1;

  latlong_to_cartesian #(.TRIG_STAGES(STAGES), .RADIUS_BITS(RBITS)) uut (
    .clk(clk), .rst(rst), .radius_we(radius_we), .radius(radius),
    .in_valid(in_valid), .in_stall(in_stall), .latitude(latitude),
    .longitude(longitude), .out_valid(out_valid), .out_stall(out_stall),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord)
  );

  always #1 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(string what);
    $display("error: %s", what);
    fail_count++;
  endtask

  // Floor division by 2^n
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint arctan_q30(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                      2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic longint round_q16(longint v);
    longint r;
    r = floor_shr(v + 8192, 14);
    if (r < 0) r = 0;
    if (r > 65536) r = 65536;
    return r;
  endfunction

  // Sine and cosine in Q16 of an angle in 1/128 degree
  function automatic void trig_q16(input logic [15:0] ang, output longint s,
                                   output longint c);
    longint unsigned a, rem;
    int     quad;
    longint x, y, z, dx, dy, rs, rc;
    a = ang % 46080;
    quad = int'(a / 11520);
    rem = a % 11520;
    z = (rem * 37480660) >> 8;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    rs = round_q16(y);
    rc = round_q16(x);
    case (quad)
      0: begin s = rs; c = rc; end
      1: begin s = rc; c = -rs; end
      2: begin s = -rs; c = -rc; end
      default: begin s = -rc; c = rs; end
    endcase
  endfunction

  // Rounded, saturated radius * a * b for Q16 factors
  function automatic logic signed [16:0] scaled_coord(longint a, longint b);
    bit neg;
    longint unsigned p, mag;
    neg = (a < 0) != (b < 0);
    p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    if (p >= 64'd4294967296) mag = radius_now;
    else mag = (p * radius_now + 64'd2147483648) >> 32;
    if (mag > 65535) mag = 65535;
    if (neg) return -$signed({1'b0, mag[15:0]});
    return $signed({1'b0, mag[15:0]});
  endfunction

  function automatic point_t predict_point(logic [15:0] lat, logic [15:0] lon);
    point_t p;
    longint sla, cla, slo, clo;
    trig_q16(lat, sla, cla);
    trig_q16(lon, slo, clo);
    p.x = scaled_coord(cla, slo);
    p.y = scaled_coord(-cla, clo);
    p.z = scaled_coord(sla, 65536);
    return p;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Send one transaction and wait for it to be taken; valid stays up after
  // the accepting edge so a back-to-back transaction needs no second write
  task automatic send_angles(logic [15:0] lat, logic [15:0] lon);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    latitude  <= lat;
    longitude <= lon;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_angles(predict_point(lat, lon));
  endtask

  // Program the radius once the pipeline is drained
  task automatic set_radius(logic [15:0] r);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    radius_we  <= 1'b1;
    radius     <= r;
    @(posedge clk);
    radius_we  <= 1'b0;
    radius_now = r & ((64'd1 << RBITS) - 1);
  endtask

  // Random stall on the result side
  always @(posedge clk) begin
    if (rst || !stall_on) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if ($urandom_range(0, 99) < 30) out_stall <= 1'b0;
  end

  // Check each accepted result
  always @(posedge clk) begin
    int r;
    if (!rst && out_valid && !out_stall) begin
      r = board.check_point(x_coord, y_coord, z_coord);
      if (r < 0) report("point with no angle pair pending");
      else if (r > 0) begin
        report($sformatf("got x=%0d y=%0d z=%0d, want x=%0d y=%0d z=%0d",
                         x_coord, y_coord, z_coord,
                         board.last.x, board.last.y, board.last.z));
      end
    end
  end

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(46080, 65535));
      1: return 16'(($urandom_range(0, 7)) * 5760 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 46079));
    endcase
  endfunction

  initial begin
    logic [15:0] corners[10] = '{16'd0, 16'd11520, 16'd23040, 16'd34560,
                                 16'd46079, 16'd46080, 16'd65535, 16'd5760,
                                 16'd11519, 16'd1};
    logic [15:0] radii[5] = '{16'hFFFF, 16'd0, 16'd1, 16'd1000, 16'hAAAA};
    board = new();
    radius_now = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: quadrant edges, wrap-around and extremes at full radius
    set_radius(16'hFFFF);
    for (int i = 0; i < 10; i++) send_angles(corners[i], corners[(i * 3) % 10]);
    send_angles(16'hFFFF, 16'h0000);
    send_angles(16'h5555, 16'hAAAA);

    // Random phases across radius settings
    for (int ph = 0; ph < 5; ph++) begin
      set_radius(ph == 0 ? radii[0] : (ph < 4 ? radii[ph] : 16'($urandom)));
      stall_on = (ph != 2);
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) send_angles(rand_angle(), rand_angle());
    end

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/l2c_pkg.sv
rtl/l2c_sincos.sv
rtl/l2c_scale.sv
rtl/latlong_to_cartesian.sv
sim/latlong_to_cartesian_tb.sv
